/* hdl/ssqa_pkg.sv */
// Shared types, widths and codes for the sensor sample qualify/average block.
package ssqa_pkg;

  // Field and state widths
  localparam int unsigned SmpW   = 16;
  localparam int unsigned AccW   = 27;
  localparam int unsigned CntW   = 11;
  localparam int unsigned RunW   = 8;
  localparam int unsigned GainW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Default largest averaging window
  localparam int unsigned MaxWindowDef = 1024;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMaxNormal  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRunLimit   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSpikeGap   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWindowLen  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgScaleGain  = 3'd4;

  typedef enum logic {
    KIND_AVG   = 1'b0,
    KIND_ERROR = 1'b1
  } report_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_ITER,
    DIV_DONE
  } div_state_e;

endpackage

/* hdl/ssqa_in_if.sv */
// Sample input channel: valid/ready handshake with one raw sample per beat.
interface ssqa_in_if;
  import ssqa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [SmpW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/ssqa_out_if.sv */
// Report output channel: valid/ready handshake with one report per beat.
interface ssqa_out_if;
  import ssqa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   report_kind;
  logic signed [SmpW-1:0] report_value;

  modport source (output valid, output report_kind, output report_value, input ready);
  modport sink   (input valid, input report_kind, input report_value, output ready);
endinterface

/* hdl/ssqa_scale.sv */
// Gain stage: registered Q8.8 multiply, truncation toward zero, 16-bit saturation.
module ssqa_scale (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [ssqa_pkg::SmpW-1:0] sample_i,
  input  logic [ssqa_pkg::GainW-1:0]       gain_i,
  output logic signed [ssqa_pkg::SmpW-1:0] scaled_o
);
  import ssqa_pkg::*;

  localparam int unsigned ProdW = SmpW + GainW + 1;
  localparam logic signed [ProdW-1:0] SatHi = ProdW'(32767);
  localparam logic signed [ProdW-1:0] SatLo = -ProdW'(32768);

  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] adj;
  logic signed [ProdW-1:0] quo;

  // Capture the product on the accepted beat
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(sample_i) * $signed({1'b0, gain_i});
    end
  end

  // Divide by 256 toward zero, then clamp
  always_comb begin
    adj = prod_q + (prod_q[ProdW-1] ? ProdW'(255) : ProdW'(0));
    quo = adj >>> 8;
    if (quo > SatHi) begin
      scaled_o = SmpW'(SatHi);
    end else if (quo < SatLo) begin
      scaled_o = SmpW'(SatLo);
    end else begin
      scaled_o = SmpW'(quo);
    end
  end

endmodule

/* hdl/ssqa_div.sv */
// Iterative signed divider: restoring, one quotient bit per cycle, truncating toward zero.
module ssqa_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ssqa_pkg::AccW-1:0] dividend_i,
  input  logic [ssqa_pkg::CntW-1:0]        divisor_i,
  output logic                             done_o,
  output logic signed [ssqa_pkg::SmpW-1:0] quot_o
);
  import ssqa_pkg::*;

  localparam int unsigned StepW = $clog2(AccW + 1);

  div_state_e          state_q, state_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [AccW-1:0]     num_q, num_d;
  logic [CntW-1:0]     den_q, den_d;
  logic [CntW-1:0]     rem_q, rem_d;
  logic                neg_q, neg_d;
  logic [CntW:0]       rem_sh;
  logic [AccW-1:0]     quot_full;

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  // Advance one quotient bit per iteration
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    rem_sh  = {rem_q, num_q[AccW-1]};
    done_o  = 1'b0;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          num_d   = dividend_i;
          den_d   = divisor_i;
          state_d = DIV_LOAD;
        end
      end
      DIV_LOAD: begin
        neg_d   = num_q[AccW-1];
        num_d   = num_q[AccW-1] ? (~num_q + AccW'(1)) : num_q;
        rem_d   = '0;
        step_d  = StepW'(AccW);
        state_d = DIV_ITER;
      end
      DIV_ITER: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = CntW'(rem_sh - {1'b0, den_q});
          num_d = {num_q[AccW-2:0], 1'b1};
        end else begin
          rem_d = CntW'(rem_sh);
          num_d = {num_q[AccW-2:0], 1'b0};
        end
        step_d = step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        done_o  = 1'b1;
        state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  // Restore the sign and keep the low 16 bits
  assign quot_full = neg_q ? (~num_q + AccW'(1)) : num_q;
  assign quot_o    = SmpW'(quot_full);

endmodule

/* hdl/sensor_sample_qualify_average.sv */
// Top level: sample qualification, windowed accumulation and average/error reporting.
// Latency: a sample is scaled on its accepting beat and evaluated the next cycle.
// A new sample is accepted only in idle, after the last one has been evaluated and any
// average from the 27-step divider and any report have been handed to the output register.
// Reports leave through an output register; a new report stalls while the last one waits.
// Reset: registers take their documented defaults; window, run and history clear.
module sensor_sample_qualify_average #(
  parameter int unsigned MAX_WINDOW = ssqa_pkg::MaxWindowDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ssqa_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ssqa_pkg::CfgDataW-1:0]    cfg_data_i,
  ssqa_in_if.sink                          smp_i,
  ssqa_out_if.source                       rpt_o
);
  import ssqa_pkg::*;

  // Configuration registers
  logic signed [SmpW-1:0] max_normal_q;
  logic [RunW-1:0]        run_limit_q;
  logic [SmpW-1:0]        spike_gap_q;
  logic [CntW-1:0]        win_len_q;
  logic [GainW-1:0]       gain_q;

  // Window state
  ctrl_state_e            state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [SmpW-1:0] prev_q, prev_d;
  logic                   have_prev_q, have_prev_d;
  logic [RunW-1:0]        run_q, run_d;

  // Pending result and output register
  report_kind_e           res_kind_q, res_kind_d;
  logic signed [SmpW-1:0] res_value_q, res_value_d;
  logic                   out_valid_q;
  report_kind_e           out_kind_q;
  logic signed [SmpW-1:0] out_value_q;
  logic                   out_load;

  // Datapath signals
  logic                   smp_beat;
  logic signed [SmpW-1:0] cur;
  logic [CntW-1:0]        win_len_eff;
  logic [CntW-1:0]        cnt_inc;
  logic                   over;
  logic [RunW-1:0]        run_inc;
  logic signed [SmpW:0]   diff;
  logic [SmpW:0]          mag;
  logic                   take_new;
  logic signed [SmpW-1:0] add_val;
  logic signed [AccW-1:0] acc_sum;
  logic signed [AccW-1:0] acc_cand;
  logic                   div_start;
  logic                   div_done;
  logic signed [SmpW-1:0] div_quot;

  assign smp_beat    = smp_i.valid && smp_i.ready;
  assign smp_i.ready = (state_q == ST_IDLE);

  ssqa_scale u_scale (
    .clk_i    (clk_i),
    .en_i     (smp_beat),
    .sample_i (smp_i.sample),
    .gain_i   (gain_q),
    .scaled_o (cur)
  );

  ssqa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_cand),
    .divisor_i  (win_len_eff),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Clamp the window length to 1..MAX_WINDOW
  always_comb begin
    if (win_len_q == '0) begin
      win_len_eff = CntW'(1);
    end else if (32'(win_len_q) > MAX_WINDOW) begin
      win_len_eff = CntW'(MAX_WINDOW);
    end else begin
      win_len_eff = win_len_q;
    end
  end

  // Qualify the scaled sample
  always_comb begin
    cnt_inc  = cnt_q + CntW'(1);
    over     = (cur > max_normal_q);
    run_inc  = (run_q != {RunW{1'b1}}) ? (run_q + RunW'(1)) : run_q;
    diff     = (SmpW+1)'(cur) - (SmpW+1)'(prev_q);
    mag      = diff[SmpW] ? (~diff + (SmpW+1)'(1)) : diff;
    take_new = !have_prev_q || (mag < {1'b0, spike_gap_q});
    add_val  = take_new ? cur : prev_q;
    acc_sum  = acc_q + AccW'(add_val);
    acc_cand = over ? acc_q : acc_sum;
  end

  // Sequence one sample through evaluate, divide and emit
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    run_d       = run_q;
    res_kind_d  = res_kind_q;
    res_value_d = res_value_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (smp_beat) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (over && (run_inc > run_limit_q)) begin
          run_d       = run_inc;
          cnt_d       = '0;
          acc_d       = '0;
          res_kind_d  = KIND_ERROR;
          res_value_d = cur;
          state_d     = ST_EMIT;
        end else begin
          if (over) begin
            run_d = run_inc;
          end else begin
            run_d = '0;
            acc_d = acc_sum;
            if (take_new) begin
              prev_d      = cur;
              have_prev_d = 1'b1;
            end
          end
          cnt_d   = cnt_inc;
          state_d = ST_IDLE;
          if (cnt_inc >= win_len_eff) begin
            div_start = 1'b1;
            cnt_d     = '0;
            acc_d     = '0;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_kind_d  = KIND_AVG;
          res_value_d = div_quot;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || rpt_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      acc_q       <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      run_q       <= run_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rpt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_kind_q  <= res_kind_d;
    res_value_q <= res_value_d;
    if (out_load) begin
      out_kind_q  <= res_kind_q;
      out_value_q <= res_value_q;
    end
  end

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_normal_q <= SmpW'(100);
      run_limit_q  <= RunW'(3);
      spike_gap_q  <= SmpW'(10);
      win_len_q    <= CntW'(10);
      gain_q       <= GainW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxNormal: max_normal_q <= SmpW'(cfg_data_i);
        CfgRunLimit:  run_limit_q  <= RunW'(cfg_data_i);
        CfgSpikeGap:  spike_gap_q  <= SmpW'(cfg_data_i);
        CfgWindowLen: win_len_q    <= CntW'(cfg_data_i);
        CfgScaleGain: gain_q       <= GainW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign rpt_o.valid        = out_valid_q;
  assign rpt_o.report_kind  = out_kind_q;
  assign rpt_o.report_value = out_value_q;

endmodule

/* bench/ssqa_report_checker.sv */
`timescale 1ns / 100ps
// Report checker: predicts sensor reports from accepted samples and compares each beat.
module ssqa_report_checker
  import ssqa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ssqa_in_if                  smp_mon,
  ssqa_out_if                 rpt_mon,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  typedef struct packed {
    report_kind_e           kind;
    logic signed [SmpW-1:0] value;
  } report_t;

  // Register shadows
  logic signed [SmpW-1:0]  lim_normal;
  logic [RunW-1:0]         run_allow;
  logic [SmpW-1:0]         jump_gap;
  logic [CntW-1:0]         win_target;
  logic [GainW-1:0]        gain_q8;

  // Window and history state
  logic [CntW-1:0]         win_fill;
  logic signed [AccW-1:0]  win_sum;
  logic signed [SmpW-1:0]  last_kept;
  logic                    have_kept;
  logic [RunW-1:0]         over_run;

  report_t                 pending_reports[$];
  int                      fails;

  // Scale by the Q8.8 gain, truncate toward zero, saturate to 16 bits
  function automatic logic signed [SmpW-1:0] apply_gain(input logic signed [SmpW-1:0] raw);
    longint prod;
    longint q;
    prod = longint'(raw) * longint'(gain_q8);
    q = prod / 256;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SmpW-1:0];
  endfunction

  // Advance the window by one sample; return 1 when it yields a report
  function automatic bit qualify_sample(input logic signed [SmpW-1:0] raw, output report_t rpt);
    logic signed [SmpW-1:0] cur;
    int                     diff;
    int unsigned            mag;
    int unsigned            len;
    int                     avg;
    cur = apply_gain(raw);
    rpt = '0;
    len = win_target;
    if (len < 1) len = 1;
    if (len > MaxWindowDef) len = MaxWindowDef;
    win_fill = win_fill + 1'b1;

    if (cur > lim_normal) begin
      if (over_run != '1) over_run = over_run + 1'b1;
      // Report the offending sample and drop the window
      if (over_run > run_allow) begin
        win_fill  = '0;
        win_sum   = '0;
        rpt.kind  = KIND_ERROR;
        rpt.value = cur;
        return 1'b1;
      end
    end else begin
      diff = int'(cur) - int'(last_kept);
      mag  = (diff < 0) ? -diff : diff;
      over_run = '0;
      if (!have_kept || mag < jump_gap) begin
        win_sum   = win_sum + cur;
        last_kept = cur;
        have_kept = 1'b1;
      end else begin
        // Spike: hold the last kept sample in its place
        win_sum = win_sum + last_kept;
      end
    end

    if (win_fill >= len) begin
      avg       = int'(win_sum) / int'(len);
      win_fill  = '0;
      win_sum   = '0;
      rpt.kind  = KIND_AVG;
      rpt.value = avg[SmpW-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    report_t made;
    report_t want;
    if (!rst_ni) begin
      lim_normal = 16'sd100;
      run_allow  = 8'd3;
      jump_gap   = 16'd10;
      win_target = 11'd10;
      gain_q8    = 16'd256;
      win_fill   = '0;
      win_sum    = '0;
      last_kept  = '0;
      have_kept  = 1'b0;
      over_run   = '0;
      fails      = 0;
      pending_reports.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMaxNormal: lim_normal = cfg_data_i;
          CfgRunLimit:  run_allow  = cfg_data_i[RunW-1:0];
          CfgSpikeGap:  jump_gap   = cfg_data_i;
          CfgWindowLen: win_target = cfg_data_i[CntW-1:0];
          CfgScaleGain: gain_q8    = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end

      // Compare a report beat against the oldest expectation
      if (rpt_mon.valid && rpt_mon.ready) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected report beat: report_kind %0d, report_value %0d",
                 rpt_mon.report_kind, $signed(rpt_mon.report_value));
          fails++;
        end else begin
          want = pending_reports.pop_front();
          if (rpt_mon.report_kind !== want.kind) begin
            $error("report_kind: expected %0d, actual %0d", want.kind, rpt_mon.report_kind);
            fails++;
          end
          if (rpt_mon.report_value !== want.value) begin
            $error("report_value: expected %0d, actual %0d",
                   want.value, $signed(rpt_mon.report_value));
            fails++;
          end
        end
      end

      // Predict from each accepted sample beat
      if (smp_mon.valid && smp_mon.ready) begin
        if (qualify_sample(smp_mon.sample, made)) pending_reports.push_back(made);
      end

      fail_cnt_o <= fails;
      pending_o  <= pending_reports.size();
    end
  end

endmodule

/* bench/sensor_sample_qualify_average_tb.sv */
`timescale 1ns / 100ps
// Testbench top: drives samples and register settings, gives the verdict.
module sensor_sample_qualify_average_tb;
  import ssqa_pkg::*;

  localparam int HoldCycles   = 400;
  localparam int DrainCycles  = 64;

  typedef struct {
    logic signed [SmpW-1:0] max_normal;
    logic [RunW-1:0]        run_limit;
    logic [SmpW-1:0]        spike_gap;
    logic [CntW-1:0]        win_len;
    logic [GainW-1:0]       gain;
  } settings_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ssqa_in_if  smp ();
  ssqa_out_if rpt ();

  int        fail_cnt;
  int        pending;
  bit        calm;
  int        hold_req;
  int        hold_ack;
  int        level;
  int        burst_left;
  settings_t cfg;

  sensor_sample_qualify_average uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .smp_i      (smp),
    .rpt_o      (rpt)
  );

  ssqa_report_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .smp_mon    (smp),
    .rpt_mon    (rpt),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Report sink: random stalls, calm stretches and one long hold-off on request
  initial begin
    rpt.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        rpt.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_ack = hold_req;
      end else if (calm) begin
        rpt.ready <= 1'b1;
      end else begin
        rpt.ready <= ($urandom_range(99) >= 34);
      end
    end
  end

  // Offer one sample beat, idling first at random; leave valid high on return
  task automatic push_sample(input logic signed [SmpW-1:0] s);
    if (!calm && $urandom_range(99) < 34) begin
      smp.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 34);
    end
    smp.valid  <= 1'b1;
    smp.sample <= s;
    do @(posedge clk_i); while (!smp.ready);
  endtask

  // Drop valid, wait for every expected report, then let the block drain
  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all five registers on consecutive edges
  task automatic load_settings(input settings_t s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgMaxNormal;
    cfg_data_i <= s.max_normal;
    @(posedge clk_i);
    cfg_idx_i  <= CfgRunLimit;
    cfg_data_i <= {8'd0, s.run_limit};
    @(posedge clk_i);
    cfg_idx_i  <= CfgSpikeGap;
    cfg_data_i <= s.spike_gap;
    @(posedge clk_i);
    cfg_idx_i  <= CfgWindowLen;
    cfg_data_i <= {5'd0, s.win_len};
    @(posedge clk_i);
    cfg_idx_i  <= CfgScaleGain;
    cfg_data_i <= s.gain;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Pick settings biased toward the extremes of every register
  function automatic settings_t random_settings();
    settings_t s;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15)      s.max_normal = 16'sh7FFF;
    else if (r < 25) s.max_normal = 16'sh8000;
    else if (r < 35) s.max_normal = 16'($urandom());
    else             s.max_normal = 16'($urandom_range(2000, 300));
    r = $urandom_range(99);
    if (r < 10)      s.run_limit = 8'd0;
    else if (r < 20) s.run_limit = 8'd254;
    else if (r < 30) s.run_limit = 8'd255;
    else if (r < 40) s.run_limit = 8'($urandom_range(255));
    else             s.run_limit = 8'($urandom_range(6));
    r = $urandom_range(99);
    if (r < 10)      s.spike_gap = 16'd0;
    else if (r < 20) s.spike_gap = 16'hFFFF;
    else if (r < 30) s.spike_gap = 16'($urandom());
    else             s.spike_gap = 16'($urandom_range(400, 5));
    r = $urandom_range(99);
    if (r < 8)       s.win_len = 11'd0;
    else if (r < 14) s.win_len = 11'd2047;
    else if (r < 20) s.win_len = 11'd1024;
    else             s.win_len = 11'($urandom_range(12, 1));
    r = $urandom_range(99);
    if (r < 10)      s.gain = 16'd0;
    else if (r < 20) s.gain = 16'hFFFF;
    else if (r < 35) s.gain = 16'($urandom());
    else             s.gain = 16'($urandom_range(320, 200));
    return s;
  endfunction

  // Mostly a slow drift with spikes and over-limit runs; some raw noise
  function automatic logic signed [SmpW-1:0] next_sample();
    int unsigned r;
    int          v;
    if (burst_left > 0) begin
      burst_left--;
      v = 32767 - int'($urandom_range(300));
      return v[SmpW-1:0];
    end
    r = $urandom_range(99);
    if (r < 70) begin
      v = level + int'($urandom_range(40)) - 20;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      level = v;
    end else if (r < 80) begin
      v = level + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(3000, 200));
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else if (r < 90) begin
      burst_left = $urandom_range(6);
      v = 32767 - int'($urandom_range(300));
    end else begin
      v = int'($urandom_range(65535)) - 32768;
    end
    return v[SmpW-1:0];
  endfunction

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CfgMaxNormal;
    cfg_data_i <= '0;
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    calm       = 1'b0;
    hold_req   = 0;
    hold_ack   = 0;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: first sample, drift, spikes, an over-limit run into error
    // reports, the field extremes and a full window average
    push_sample(16'sd0);
    push_sample(-16'sd1);
    push_sample(16'sd5);
    push_sample(16'sd100);
    push_sample(16'sd101);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sd200);
    push_sample(16'sh8000);
    for (int k = 6; k <= 14; k++) push_sample(16'(k));
    push_sample(16'sd100);
    push_sample(-16'sd100);
    settle();

    // Window of one with full gain: every beat reports; hold the sink to back up
    cfg = '{max_normal: 16'sh7FFF, run_limit: 8'd0, spike_gap: 16'hFFFF,
            win_len: 11'd1, gain: 16'hFFFF};
    load_settings(cfg);
    hold_req++;
    repeat (30) push_sample(16'($urandom()));
    settle();

    // Zero gain under the lowest limit: every sample is an error report
    cfg = '{max_normal: 16'sh8000, run_limit: 8'd0, spike_gap: 16'd0,
            win_len: 11'd0, gain: 16'd0};
    load_settings(cfg);
    repeat (10) push_sample(16'($urandom()));
    settle();

    // Saturated run limit, oversized window, then shorten it mid-window
    cfg = '{max_normal: 16'sd0, run_limit: 8'd255, spike_gap: 16'hFFFF,
            win_len: 11'd2047, gain: 16'd256};
    load_settings(cfg);
    repeat (30) push_sample(16'($urandom()));
    settle();
    cfg.win_len = 11'd3;
    load_settings(cfg);
    push_sample(16'sd7);
    settle();

    // Random settings, each with a run of shaped samples
    for (int p = 0; p < 8; p++) begin
      cfg = random_settings();
      load_settings(cfg);
      level      = int'($urandom_range(200)) - 100;
      burst_left = 0;
      calm       = (p == 3);
      repeat (40) push_sample(next_sample());
      settle();
      calm = 1'b0;
    end

    if (fail_cnt == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hdl/ssqa_pkg.sv
hdl/ssqa_in_if.sv
hdl/ssqa_out_if.sv
hdl/ssqa_scale.sv
hdl/ssqa_div.sv
hdl/sensor_sample_qualify_average.sv
bench/ssqa_report_checker.sv
bench/sensor_sample_qualify_average_tb.sv
